[design/kdq_pkg.sv]
`timescale 1ns / 1ps
// kdq_pkg: request, status and cell control types for the keyed deque store.
// No dependencies; used by kdq_cell and keyed_deque_store_unit.
package kdq_pkg;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_KEY   = 3'd3,
        REQ_LOOKUP    = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // What every cell does in the commit cycle.
    typedef enum logic [2:0] {
        CELL_NONE,
        CELL_INS_FRONT,
        CELL_INS_BACK,
        CELL_REM_FRONT,
        CELL_REM_KEY
    } t_cell_op;

    typedef struct packed {
        logic     match_en;
        logic     exec;
        t_cell_op op;
    } t_cell_ctl;

endpackage

[design/kdq_cell.sv]
`timescale 1ns / 1ps
// kdq_cell: one slot of the store; holds key, value and valid, shifts with neighbors.
// Depends on kdq_pkg.
module kdq_cell import kdq_pkg::*; #(
    parameter int KEY_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [63:0]         i_value,
    input  logic [KEY_BITS-1:0] i_prev_key,
    input  logic [63:0]         i_prev_value,
    input  logic                i_prev_valid,
    input  logic [KEY_BITS-1:0] i_next_key,
    input  logic [63:0]         i_next_value,
    input  logic                i_next_valid,
    input  logic                i_hit,
    input  logic [63:0]         i_chain_value,
    output logic [KEY_BITS-1:0] o_key,
    output logic [63:0]         o_value,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_nkey,
    output logic [63:0]         o_nvalue,
    output logic                o_nvalid,
    output logic                o_hit,
    output logic [63:0]         o_chain_value
);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [63:0]         r_value, n_value;
    logic                r_valid, n_valid;
    logic                r_match;

    // Prefix of matches from the front; first match passes its value on.
    assign o_hit         = i_hit | r_match;
    assign o_chain_value = i_hit ? i_chain_value : (r_match ? r_value : '0);

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.exec) begin
            unique case (i_ctl.op)
                CELL_INS_FRONT: begin
                    n_key   = i_prev_key;
                    n_value = i_prev_value;
                    n_valid = i_prev_valid;
                end
                CELL_INS_BACK: begin
                    // first empty slot takes the request pair
                    if (!r_valid && i_prev_valid) begin
                        n_key   = i_key;
                        n_value = i_value;
                        n_valid = 1'b1;
                    end
                end
                CELL_REM_FRONT: begin
                    n_key   = i_next_key;
                    n_value = i_next_value;
                    n_valid = i_next_valid;
                end
                CELL_REM_KEY: begin
                    if (i_hit || r_match) begin
                        n_key   = i_next_key;
                        n_value = i_next_value;
                        n_valid = i_next_valid;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.match_en) begin
                r_match <= r_valid && (r_key == i_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key    = r_key;
    assign o_value  = r_value;
    assign o_valid  = r_valid;
    assign o_nkey   = n_key;
    assign o_nvalue = n_value;
    assign o_nvalid = n_valid;

endmodule

[design/keyed_deque_store_unit.sv]
`timescale 1ns / 1ps
// keyed_deque_store_unit: top level of the keyed deque store, a row of DEPTH cells.
// Depends on kdq_pkg and kdq_cell.
//
// The store keeps up to DEPTH (key, value) pairs in order, front in cell 0,
// each cell holding one pair plus a valid flag. A request passes a match and a
// commit state: in the match state every cell compares its key against the
// request key at once; in the commit state the match flags ripple down the row
// to find the match nearest the front, the row shifts one place (toward the back
// on insert front, toward the front from the removed slot on removes; insert
// back fills the first empty cell, lookups keep the row) and the result beat is
// loaded into the output register. The next request beat is taken in that
// same commit cycle. The critical path is the key compare in the match state
// and the hit and value chain through all DEPTH cells in the commit state. A
// result waiting on o_out_valid does not block the next request beat; only the
// commit cycle waits for the output register to be free. Keys are held in
// KEY_BITS bits: wider input key bits are dropped, narrower stored keys read
// back zero-extended. Unused request codes leave the store unchanged and report ok with the current front.
module keyed_deque_store_unit import kdq_pkg::*; #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_key,
    input  logic [63:0] i_payload,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [63:0] o_found_value,
    output logic [31:0] o_front_key,
    output logic [63:0] o_front_value,
    output logic [4:0]  o_count
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_MATCH, S_EXEC} t_state;

    t_state              r_state;
    logic [2:0]          r_req;
    logic [KEY_BITS-1:0] r_key;
    logic [63:0]         r_value;
    logic [CW-1:0]       r_count, n_count;

    logic                r_out_valid;
    t_status             r_status;
    logic                r_found;
    logic [63:0]         r_found_value;
    logic [31:0]         r_front_key;
    logic [63:0]         r_front_value;
    logic [4:0]          r_out_count;

    logic                w_out_free, w_commit, w_accept;
    t_cell_op            w_op;
    t_status             w_status;
    logic                w_found;
    logic [63:0]         w_found_value;
    t_cell_ctl           w_ctl;

    logic [KEY_BITS+31:0] w_in_key_ext;
    logic [KEY_BITS+31:0] w_front_ext;
    logic [CW+4:0]        w_cnt_ext;

    // cell row wiring
    logic [KEY_BITS-1:0] w_key   [DEPTH];
    logic [63:0]         w_value [DEPTH];
    logic                w_valid [DEPTH];
    logic [KEY_BITS-1:0] w_nkey  [DEPTH];
    logic [63:0]         w_nvalue[DEPTH];
    logic                w_nvalid[DEPTH];
    logic                w_hit   [DEPTH];
    logic [63:0]         w_chain [DEPTH];

    // Handshake: free to take a beat when idle or in the commit cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_commit   = (r_state == S_EXEC) && w_out_free;
    assign o_in_stall = !((r_state == S_IDLE) || w_commit);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_in_key_ext = (KEY_BITS + 32)'(i_key);

    assign w_ctl.match_en = (r_state == S_MATCH);
    assign w_ctl.exec     = w_commit;
    assign w_ctl.op       = w_op;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_BITS-1:0] w_pk, w_nk;
            logic [63:0]         w_pv, w_nv, w_cin;
            logic                w_pvl, w_nvl, w_hin;

            if (g == 0) begin : g_head
                // The new pair stands in front of cell 0.
                assign w_pk  = r_key;
                assign w_pv  = r_value;
                assign w_pvl = 1'b1;
                assign w_hin = 1'b0;
                assign w_cin = '0;
            end else begin : g_body
                assign w_pk  = w_key[g-1];
                assign w_pv  = w_value[g-1];
                assign w_pvl = w_valid[g-1];
                assign w_hin = w_hit[g-1];
                assign w_cin = w_chain[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_nk  = '0;
                assign w_nv  = '0;
                assign w_nvl = 1'b0;
            end else begin : g_inner
                assign w_nk  = w_key[g+1];
                assign w_nv  = w_value[g+1];
                assign w_nvl = w_valid[g+1];
            end

            kdq_cell #(
                .KEY_BITS(KEY_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (r_key),
                .i_value      (r_value),
                .i_prev_key   (w_pk),
                .i_prev_value (w_pv),
                .i_prev_valid (w_pvl),
                .i_next_key   (w_nk),
                .i_next_value (w_nv),
                .i_next_valid (w_nvl),
                .i_hit        (w_hin),
                .i_chain_value(w_cin),
                .o_key        (w_key[g]),
                .o_value      (w_value[g]),
                .o_valid      (w_valid[g]),
                .o_nkey       (w_nkey[g]),
                .o_nvalue     (w_nvalue[g]),
                .o_nvalid     (w_nvalid[g]),
                .o_hit        (w_hit[g]),
                .o_chain_value(w_chain[g])
            );
        end
    endgenerate

    // Decode the request against the current fill and the match chain.
    always_comb begin
        w_op          = CELL_NONE;
        w_status      = ST_OK;
        w_found       = 1'b0;
        w_found_value = '0;
        n_count       = r_count;
        unique case (r_req)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (r_count == CW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_op    = (r_req == REQ_INS_FRONT) ? CELL_INS_FRONT : CELL_INS_BACK;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_REM_FRONT: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op    = CELL_REM_FRONT;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_REM_KEY: begin
                if (w_hit[DEPTH-1]) begin
                    w_op    = CELL_REM_KEY;
                    w_found = 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            REQ_LOOKUP: begin
                if (w_hit[DEPTH-1]) begin
                    w_found       = 1'b1;
                    w_found_value = w_chain[DEPTH-1];
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // Front after the commit comes from cell 0's next value.
    assign w_front_ext = (KEY_BITS + 32)'(w_nkey[0]);
    assign w_cnt_ext   = (CW + 5)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_state     <= w_accept ? S_MATCH : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req_type;
            r_key   <= w_in_key_ext[KEY_BITS-1:0];
            r_value <= i_payload;
        end
        if (w_commit) begin
            r_status      <= w_status;
            r_found       <= w_found;
            r_found_value <= w_found_value;
            r_front_key   <= w_nvalid[0] ? w_front_ext[31:0] : '0;
            r_front_value <= w_nvalid[0] ? w_nvalue[0] : '0;
            r_out_count   <= w_cnt_ext[4:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_found_value = r_found_value;
    assign o_front_key   = r_front_key;
    assign o_front_value = r_front_value;
    assign o_count       = r_out_count;

endmodule
